@@ hdl/fmb_pkg.sv @@
// Shared types, constants and arithmetic helpers for the Fock matrix build core.
// Depends on nothing; every other file refers to it by scoped name.
package fmb_pkg;

    localparam int BASIS_SIZE = 8;
    localparam int IDX_W      = 3;
    localparam int ADDR_W     = 2 * IDX_W;
    localparam int DEPTH      = 2 ** ADDR_W;
    localparam int Q_W        = 48;
    localparam int PART_W     = Q_W / 2;
    localparam int PP_W       = 2 * (PART_W + 1);
    localparam int PROD_W     = 2 * Q_W;
    localparam int FRAC_W     = 32;
    localparam int SUM_W      = Q_W + 3;

    typedef enum logic [1:0] {
        CMD_LOAD_CORE    = 2'd0,
        CMD_LOAD_DENSITY = 2'd1,
        CMD_INTEGRAL     = 2'd2,
        CMD_READ         = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LD_CD,
        ST_MUL_CD,
        ST_MUL_BD,
        ST_UPD_AB,
        ST_UPD_AC,
        ST_RD_F
    } fsm_t;

    typedef struct packed {
        cmd_t                    command;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic [IDX_W-1:0]        third_index;
        logic [IDX_W-1:0]        fourth_index;
        logic signed [Q_W-1:0]   value;
    } in_req_t;

    typedef struct packed {
        logic [IDX_W-1:0]        out_row;
        logic [IDX_W-1:0]        out_col;
        logic signed [Q_W-1:0]   fock_value;
    } out_rsp_t;

    typedef struct packed {
        logic                    start;
        logic signed [Q_W-1:0]   a;
        logic signed [Q_W-1:0]   b;
    } mul_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [Q_W-1:0]   product;
    } mul_rsp_t;

    localparam logic signed [Q_W-1:0] MAXQ = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] MINQ = {1'b1, {(Q_W-1){1'b0}}};

    function automatic logic idx_ok(logic [IDX_W-1:0] i);
        return int'(i) < BASIS_SIZE;
    endfunction

    // Floor shift of a full product to Q15.32, then clamp to the 48-bit range.
    function automatic logic signed [Q_W-1:0] sat_prod(logic signed [PROD_W-1:0] p);
        logic [PROD_W-FRAC_W-Q_W:0] top;
        top = p[PROD_W-1:FRAC_W+Q_W-1];
        if ((top == '0) || (top == '1))
            return p[FRAC_W+Q_W-1:FRAC_W];
        return p[PROD_W-1] ? MINQ : MAXQ;
    endfunction

    function automatic logic signed [Q_W-1:0] sat_sum(logic signed [SUM_W-1:0] s);
        logic [SUM_W-Q_W:0] top;
        top = s[SUM_W-1:Q_W-1];
        if ((top == '0) || (top == '1))
            return s[Q_W-1:0];
        return s[SUM_W-1] ? MINQ : MAXQ;
    endfunction

endpackage

@@ hdl/fock_matrix_build_core.sv @@
// Top level of the closed-shell Fock build: Fock and density memories, command
// sequencer and result register. Depends on fmb_pkg and fmb_mul.
//
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_ready | fmb_pkg::in_req_t
//  rsp     | out       | rsp_valid / rsp_ready | fmb_pkg::out_rsp_t
//
// A load with indices in range writes its memory when accepted; a read may wait
// for the result register. An integral forms two Q15.32 products, each four partial
// products through the one 25x25 multiplier, then does one read-modify-write of
// the Fock memory when the second and third indices are equal, two otherwise.
// Memories are not cleared by reset; reset clears the sequencer and the result
// valid flag. A stalled result holds the sequencer in the read state, and no
// request is taken until the result register frees.
module fock_matrix_build_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  fmb_pkg::in_req_t   req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output fmb_pkg::out_rsp_t  rsp
);

    logic signed [fmb_pkg::Q_W-1:0]   fock_mem [fmb_pkg::DEPTH];
    logic signed [fmb_pkg::Q_W-1:0]   dens_mem [fmb_pkg::DEPTH];

    fmb_pkg::fsm_t                    state_reg, state_next;
    fmb_pkg::in_req_t                 item_reg;
    logic                             ok_reg, ok_next;
    logic signed [fmb_pkg::Q_W:0]     coul_reg;
    logic signed [fmb_pkg::Q_W-1:0]   exch_reg;
    logic                             coul_load, exch_load;
    logic                             out_valid_reg, out_valid_next;
    fmb_pkg::out_rsp_t                out_reg;
    logic                             out_load;

    logic                             fock_we, fock_re;
    logic [fmb_pkg::ADDR_W-1:0]       fock_waddr, fock_raddr;
    logic signed [fmb_pkg::Q_W-1:0]   fock_wdata, fock_q_reg;
    logic                             dens_we, dens_re;
    logic [fmb_pkg::ADDR_W-1:0]       dens_waddr, dens_raddr;
    logic signed [fmb_pkg::Q_W-1:0]   dens_q_reg;

    logic                             accept;
    logic signed [fmb_pkg::SUM_W-1:0] sum;
    fmb_pkg::mul_req_t                mul_req;
    fmb_pkg::mul_rsp_t                mul_rsp;

    fmb_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    assign req_ready = (state_reg == fmb_pkg::ST_IDLE);
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        state_next = state_reg;
        ok_next    = ok_reg;
        fock_we    = 1'b0;
        fock_re    = 1'b0;
        fock_waddr = {item_reg.row, item_reg.col};
        fock_raddr = {item_reg.row, item_reg.col};
        fock_wdata = req.value;
        dens_we    = 1'b0;
        dens_re    = 1'b0;
        dens_waddr = {req.row, req.col};
        dens_raddr = {item_reg.third_index, item_reg.fourth_index};
        coul_load  = 1'b0;
        exch_load  = 1'b0;
        out_load   = 1'b0;
        sum        = '0;
        mul_req.start = 1'b0;
        mul_req.a     = dens_q_reg;
        mul_req.b     = item_reg.value;

        case (state_reg)
            fmb_pkg::ST_IDLE:
            begin
                ok_next = fmb_pkg::idx_ok(req.row) && fmb_pkg::idx_ok(req.col);
                fock_waddr = {req.row, req.col};
                fock_raddr = {req.row, req.col};
                if (accept)
                begin
                    case (req.command)
                        fmb_pkg::CMD_LOAD_CORE:
                            fock_we = ok_next;
                        fmb_pkg::CMD_LOAD_DENSITY:
                            dens_we = ok_next;
                        fmb_pkg::CMD_INTEGRAL:
                        begin
                            // drop an integral with any index out of range
                            if (ok_next && fmb_pkg::idx_ok(req.third_index)
                                && fmb_pkg::idx_ok(req.fourth_index))
                            begin
                                dens_re    = 1'b1;
                                dens_raddr = {req.third_index, req.fourth_index};
                                state_next = fmb_pkg::ST_LD_CD;
                            end
                        end
                        fmb_pkg::CMD_READ:
                        begin
                            fock_re    = ok_next;
                            state_next = fmb_pkg::ST_RD_F;
                        end
                        default:
                            state_next = fmb_pkg::ST_IDLE;
                    endcase
                end
            end
            fmb_pkg::ST_LD_CD:
            begin
                mul_req.start = 1'b1;
                dens_re       = 1'b1;
                dens_raddr    = {item_reg.col, item_reg.fourth_index};
                state_next    = fmb_pkg::ST_MUL_CD;
            end
            fmb_pkg::ST_MUL_CD:
            begin
                if (mul_rsp.done)
                begin
                    coul_load     = 1'b1;
                    mul_req.start = 1'b1;
                    state_next    = fmb_pkg::ST_MUL_BD;
                end
            end
            fmb_pkg::ST_MUL_BD:
            begin
                if (mul_rsp.done)
                begin
                    exch_load  = 1'b1;
                    fock_re    = 1'b1;
                    state_next = fmb_pkg::ST_UPD_AB;
                end
            end
            fmb_pkg::ST_UPD_AB:
            begin
                // combine both deltas when the two updates land on one entry
                sum = {{3{fock_q_reg[fmb_pkg::Q_W-1]}}, fock_q_reg}
                    + {{2{coul_reg[fmb_pkg::Q_W]}}, coul_reg};
                if (item_reg.col == item_reg.third_index)
                    sum = sum - {{3{exch_reg[fmb_pkg::Q_W-1]}}, exch_reg};
                fock_we    = 1'b1;
                fock_wdata = fmb_pkg::sat_sum(sum);
                if (item_reg.col == item_reg.third_index)
                    state_next = fmb_pkg::ST_IDLE;
                else
                begin
                    fock_re    = 1'b1;
                    fock_raddr = {item_reg.row, item_reg.third_index};
                    state_next = fmb_pkg::ST_UPD_AC;
                end
            end
            fmb_pkg::ST_UPD_AC:
            begin
                sum = {{3{fock_q_reg[fmb_pkg::Q_W-1]}}, fock_q_reg}
                    - {{3{exch_reg[fmb_pkg::Q_W-1]}}, exch_reg};
                fock_we    = 1'b1;
                fock_waddr = {item_reg.row, item_reg.third_index};
                fock_wdata = fmb_pkg::sat_sum(sum);
                state_next = fmb_pkg::ST_IDLE;
            end
            fmb_pkg::ST_RD_F:
            begin
                // hold until the result register is free
                if (!out_valid_reg || rsp_ready)
                begin
                    out_load   = 1'b1;
                    state_next = fmb_pkg::ST_IDLE;
                end
            end
            default:
                state_next = fmb_pkg::ST_IDLE;
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && !rsp_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fmb_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            ok_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            ok_reg        <= ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= req;
        if (coul_load)
            coul_reg <= {mul_rsp.product, 1'b0};
        if (exch_load)
            exch_reg <= mul_rsp.product;
        if (out_load)
        begin
            out_reg.out_row    <= item_reg.row;
            out_reg.out_col    <= item_reg.col;
            out_reg.fock_value <= ok_reg ? fock_q_reg : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fock_we)
            fock_mem[fock_waddr] <= fock_wdata;
        if (fock_re)
            fock_q_reg <= fock_mem[fock_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (dens_we)
            dens_mem[dens_waddr] <= req.value;
        if (dens_re)
            dens_q_reg <= dens_mem[dens_raddr];
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

`ifndef SYNTHESIS
    a_mul_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        mul_rsp.done |-> (state_reg == fmb_pkg::ST_MUL_CD
                          || state_reg == fmb_pkg::ST_MUL_BD))
        else $error("multiplier result outside a multiply state");

    a_fock_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (fock_we && fock_re) |-> (fock_waddr != fock_raddr))
        else $error("Fock memory read and write hit one entry");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fmb_pkg::ST_RD_F && out_valid_reg && !rsp_ready)
        |=> (state_reg == fmb_pkg::ST_RD_F))
        else $error("pending read left its state with the result register full");
`endif

endmodule

@@ hdl/fmb_mul.sv @@
// Iterative Q15.32 multiplier: one 25x25 signed multiply per cycle, four partial
// products per result, floor truncation and saturation. Depends on fmb_pkg.
module fmb_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  fmb_pkg::mul_req_t req,
    output fmb_pkg::mul_rsp_t rsp
);

    logic                                  busy_reg;
    logic                                  fin_reg;
    logic                                  done_reg;
    logic [1:0]                            step_reg;
    logic signed [fmb_pkg::Q_W-1:0]        a_reg;
    logic signed [fmb_pkg::Q_W-1:0]        b_reg;
    logic signed [fmb_pkg::PROD_W-1:0]     acc_reg;
    logic signed [fmb_pkg::PROD_W-1:0]     acc_next;
    logic signed [fmb_pkg::Q_W-1:0]        result_reg;
    logic signed [fmb_pkg::PART_W:0]       a_part;
    logic signed [fmb_pkg::PART_W:0]       b_part;
    logic signed [fmb_pkg::PP_W-1:0]       pp;
    logic signed [fmb_pkg::PROD_W-1:0]     pp_wide;
    logic signed [fmb_pkg::PROD_W-1:0]     pp_shift;

    // Low halves are unsigned, high halves carry the sign.
    assign a_part = step_reg[0]
        ? {a_reg[fmb_pkg::Q_W-1], a_reg[fmb_pkg::Q_W-1:fmb_pkg::PART_W]}
        : {1'b0, a_reg[fmb_pkg::PART_W-1:0]};
    assign b_part = step_reg[1]
        ? {b_reg[fmb_pkg::Q_W-1], b_reg[fmb_pkg::Q_W-1:fmb_pkg::PART_W]}
        : {1'b0, b_reg[fmb_pkg::PART_W-1:0]};
    assign pp      = a_part * b_part;
    assign pp_wide = {{(fmb_pkg::PROD_W-fmb_pkg::PP_W){pp[fmb_pkg::PP_W-1]}}, pp};

    always_comb
    begin
        case (step_reg)
            2'd0:    pp_shift = pp_wide;
            2'd3:    pp_shift = pp_wide <<< (2 * fmb_pkg::PART_W);
            default: pp_shift = pp_wide <<< fmb_pkg::PART_W;
        endcase
        acc_next = acc_reg + pp_shift;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 2'd0;
        end
        else
        begin
            fin_reg  <= busy_reg && (step_reg == 2'd3);
            done_reg <= fin_reg;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 2'd0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd3)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            acc_reg <= '0;
        end
        else if (busy_reg)
            acc_reg <= acc_next;
        if (fin_reg)
            result_reg <= fmb_pkg::sat_prod(acc_reg);
    end

    assign rsp.done    = done_reg;
    assign rsp.product = result_reg;

endmodule
